// ===== rtl/wti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted table interpolator package
// Default table geometry, command codes, port widths and the fixed-point constants.
// ----------------------------------------------------------------------------
package wti_pkg;

   // Default table geometry, handed to the top level as parameter defaults.
   localparam int SENSORS_DEFAULT   = 16;
   localparam int Z_POINTS_DEFAULT  = 4;
   localparam int Y_POINTS_DEFAULT  = 4;
   localparam int TIME_BINS_DEFAULT = 1024;

   // Two recoil hypotheses per grid point.
   localparam int HYPOTHESES = 2;

   // Request command codes.
   typedef enum logic {CMD_WRITE = 1'b0, CMD_QUERY = 1'b1} command_type;

   // Time axis in Q.8 nanoseconds: clamp window and the offset to bin numbers.
   localparam logic signed [19:0] TIME_LOW_Q8    = -20'sd12800;
   localparam logic signed [19:0] TIME_HIGH_Q8   = 20'sd140544;
   localparam logic        [17:0] TIME_OFFSET_Q8 = 18'd13056;

   // Rounding bias for the Q.40 to Q16.16 step.
   localparam logic [41:0] ROUND_HALF = 42'd8388608;

   // Port widths fixed by the item format.
   localparam int TIME_W   = 20;
   localparam int WEIGHT_W = 17;
   localparam int BIN_W    = 10;
   localparam int ENTRY_W  = 32;
   localparam int SUM_W    = 48;

endpackage

// ===== rtl/weighted_table_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted table interpolator
// Histogram table with linear interpolation in time and a weighted running
// sum over grid corners, emitted on the corner flagged last.
// ----------------------------------------------------------------------------
//
//   Channel   Ports           Direction   Beat carries
//   -------   -------------   ---------   ------------------------------------
//   request   req_*           in          table write or one corner query
//   response  rsp_*           out         likelihood sum after the last corner
//
// A query beat holds the block through address setup, two table reads, three
// multiplier passes and the accumulate step; a table write goes through address
// setup and the write step. The single-port table memory, read twice per query,
// and the one shared multiplier, used three times per query, set these steps.
// Reset clears the sequencer, the running sum and the response valid; the
// table itself holds whatever it held and must be written before it is read.
// A pending response beat does not block new requests; only a second sum that
// finds the response register still stalled waits in the accumulate step.
//
module weighted_table_interpolator #(
   parameter int SENSORS   = wti_pkg::SENSORS_DEFAULT,
   parameter int Z_POINTS  = wti_pkg::Z_POINTS_DEFAULT,
   parameter int Y_POINTS  = wti_pkg::Y_POINTS_DEFAULT,
   parameter int TIME_BINS = wti_pkg::TIME_BINS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [3:0]                           req_sensor_index,
   input  logic                                 req_hypothesis,
   input  logic [1:0]                           req_y_index,
   input  logic [1:0]                           req_z_index,
   input  logic signed [wti_pkg::TIME_W-1:0]    req_time_value,
   input  logic [wti_pkg::WEIGHT_W-1:0]         req_corner_weight,
   input  logic                                 req_last_corner,
   input  logic [wti_pkg::BIN_W-1:0]            req_entry_bin,
   input  logic signed [wti_pkg::ENTRY_W-1:0]   req_entry_value,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [wti_pkg::SUM_W-1:0]     rsp_likelihood_sum
);

   // Table geometry. Each row holds the time histogram of one sensor, grid
   // point and hypothesis; rows are laid out back to back.
   localparam int DEPTH  = SENSORS * Z_POINTS * Y_POINTS * wti_pkg::HYPOTHESES * TIME_BINS;
   localparam int ADDR_W = $clog2(DEPTH);

   // The sequencer walks a query through address setup, two table reads and three passes
   // through the shared multiplier before accumulating; a write goes from address setup to the write step.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADDR,
      ST_WRITE,
      ST_RD0,
      ST_RD1,
      ST_MUL0,
      ST_FVAL,
      ST_LO,
      ST_HI,
      ST_ACC
   } state_type;

   state_type state_ff, state_in;

   // Captured request fields.
   logic                             command_ff;
   logic [3:0]                       sensor_ff;
   logic                             hyp_ff;
   logic [1:0]                       y_ff;
   logic [1:0]                       z_ff;
   logic [wti_pkg::BIN_W-1:0]        bin_ff;
   logic [7:0]                       frac_ff;
   logic [wti_pkg::WEIGHT_W-1:0]     weight_ff;
   logic                             last_ff;
   logic [wti_pkg::BIN_W-1:0]        entry_bin_ff;
   logic [wti_pkg::ENTRY_W-1:0]      entry_value_ff;

   // Address and datapath registers.
   logic [ADDR_W-1:0]                base_ff;
   logic                             in_range_ff;
   logic signed [wti_pkg::ENTRY_W-1:0] rdata_ff;
   logic signed [wti_pkg::ENTRY_W-1:0] c1_ff;
   logic signed [51:0]               prod_ff;
   logic signed [39:0]               f_ff;
   logic [17:0]                      carry_ff;
   logic [wti_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [wti_pkg::SUM_W-1:0]        rsp_sum_ff;

   // The table memory.
   logic [wti_pkg::ENTRY_W-1:0]      table_mem [DEPTH];
   logic                             mem_we;
   logic                             mem_re;
   logic [ADDR_W-1:0]                mem_addr;

   // ---------------------------------------------------------------------
   // Time clamp and split into bin number and fraction, taken at accept.
   // ---------------------------------------------------------------------
   logic signed [wti_pkg::TIME_W-1:0] time_clamped;
   logic [17:0]                       time_shifted;

   always_comb begin
      if (req_time_value < wti_pkg::TIME_LOW_Q8) begin
         time_clamped = wti_pkg::TIME_LOW_Q8;
      end else if (req_time_value > wti_pkg::TIME_HIGH_Q8) begin
         time_clamped = wti_pkg::TIME_HIGH_Q8;
      end else begin
         time_clamped = req_time_value;
      end
      time_shifted = 18'(time_clamped) + wti_pkg::TIME_OFFSET_Q8;
   end

   // ---------------------------------------------------------------------
   // Row address and range check from the captured indices.
   // ---------------------------------------------------------------------
   logic [ADDR_W-1:0] row_index;
   logic [ADDR_W-1:0] base_in;
   logic              index_ok;

   always_comb begin
      row_index = ((ADDR_W'(sensor_ff) * ADDR_W'(Z_POINTS) + ADDR_W'(z_ff))
                   * ADDR_W'(Y_POINTS) + ADDR_W'(y_ff))
                  * ADDR_W'(wti_pkg::HYPOTHESES) + ADDR_W'(hyp_ff);
      base_in   = row_index * ADDR_W'(TIME_BINS);
      index_ok  = (32'(sensor_ff) < 32'(SENSORS)) &&
                  (32'(z_ff) < 32'(Z_POINTS)) &&
                  (32'(y_ff) < 32'(Y_POINTS));
   end

   // ---------------------------------------------------------------------
   // Memory port control. The query bins never leave the row, so only the
   // write bin needs its own check.
   // ---------------------------------------------------------------------
   always_comb begin
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      mem_addr = base_ff;
      case (state_ff)
         ST_WRITE: begin
            mem_we   = in_range_ff && (32'(entry_bin_ff) < 32'(TIME_BINS));
            mem_addr = base_ff + ADDR_W'(entry_bin_ff);
         end
         ST_RD0: begin
            mem_re   = in_range_ff;
            mem_addr = base_ff + ADDR_W'(bin_ff);
         end
         ST_RD1: begin
            mem_re   = in_range_ff;
            mem_addr = base_ff + ADDR_W'(bin_ff) + ADDR_W'(1);
         end
         default: begin
            mem_we   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_addr] <= entry_value_ff;
      end
      if (mem_re) begin
         rdata_ff <= table_mem[mem_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Shared multiplier. Pass one forms frac * (c2 - c1); passes two and
   // three multiply the low 24 and the high 16 bits of the interpolated
   // value by the weight, so the Q.40 product never has to be formed whole.
   // ---------------------------------------------------------------------
   logic signed [wti_pkg::ENTRY_W-1:0] c2_eff;
   logic signed [32:0]                 diff;
   logic signed [33:0]                 mul_a;
   logic signed [17:0]                 mul_b;
   logic signed [51:0]                 mul_p;
   logic signed [39:0]                 f_in;
   logic [41:0]                        carry_sum;
   logic [wti_pkg::SUM_W-1:0]          term;

   always_comb begin
      c2_eff = in_range_ff ? rdata_ff : '0;
      diff   = {c2_eff[31], c2_eff} - {c1_ff[31], c1_ff};
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         ST_MUL0: begin
            mul_a = {diff[32], diff};
            mul_b = {10'd0, frac_ff};
         end
         ST_LO: begin
            mul_a = {10'd0, f_ff[23:0]};
            mul_b = {1'b0, weight_ff};
         end
         ST_HI: begin
            mul_a = {{18{f_ff[39]}}, f_ff[39:24]};
            mul_b = {1'b0, weight_ff};
         end
         default: begin
            mul_a = '0;
         end
      endcase
      mul_p = mul_a * mul_b;

      // The interpolated value always fits 40 bits, so the sum may wrap there.
      f_in      = ({{8{c1_ff[31]}}, c1_ff} <<< 8) + prod_ff[39:0];
      carry_sum = prod_ff[41:0] + wti_pkg::ROUND_HALF;
      term      = prod_ff[47:0] + {30'd0, carry_ff};
   end

   // ---------------------------------------------------------------------
   // Sequencer next state and running sum.
   // ---------------------------------------------------------------------
   logic req_take;
   logic rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = (command_ff == wti_pkg::CMD_QUERY) ? ST_RD0 : ST_WRITE;
         end
         ST_WRITE: state_in = ST_IDLE;
         ST_RD0:   state_in = ST_RD1;
         ST_RD1:   state_in = ST_MUL0;
         ST_MUL0:  state_in = ST_FVAL;
         ST_FVAL:  state_in = ST_LO;
         ST_LO:    state_in = ST_HI;
         ST_HI:    state_in = ST_ACC;
         ST_ACC: begin
            if (!last_ff) begin
               sum_in   = sum_ff + term;
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               sum_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end

      if (req_take) begin
         command_ff     <= req_command;
         sensor_ff      <= req_sensor_index;
         hyp_ff         <= req_hypothesis;
         y_ff           <= req_y_index;
         z_ff           <= req_z_index;
         bin_ff         <= time_shifted[17:8];
         frac_ff        <= time_shifted[7:0];
         weight_ff      <= req_corner_weight;
         last_ff        <= req_last_corner;
         entry_bin_ff   <= req_entry_bin;
         entry_value_ff <= req_entry_value;
      end
      if (state_ff == ST_ADDR) begin
         base_ff     <= base_in;
         in_range_ff <= index_ok;
      end
      if (state_ff == ST_MUL0) begin
         // Out-of-range queries read as zero.
      end
      if (state_ff == ST_RD1) begin
         c1_ff <= in_range_ff ? rdata_ff : '0;
      end
      if (state_ff == ST_FVAL) begin
         f_ff <= f_in;
      end
      if (state_ff == ST_HI) begin
         carry_ff <= carry_sum[41:24];
      end
      // The product register only loads on a multiplier pass, so the high
      // product survives while a final corner waits in the accumulate step.
      if (state_ff == ST_MUL0 || state_ff == ST_LO || state_ff == ST_HI) begin
         prod_ff <= mul_p;
      end
      if (state_ff == ST_ACC && last_ff && rsp_free) begin
         rsp_sum_ff <= sum_ff + term;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_likelihood_sum = rsp_sum_ff;

`ifndef SYNTHESIS
   // A request beat always starts the address step.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_ADDR)
      else $error("accepted request did not start the sequencer");

   // Table writes come only right after the address step.
   a_write_timing: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> $past(state_ff == ST_ADDR))
      else $error("table write outside its slot");

   // The second read is the bin after the first.
   a_adjacent_bins: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD1 |-> mem_addr == $past(mem_addr) + ADDR_W'(1))
      else $error("second bin read is not adjacent");

   // A corner without the last flag never raises a response.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && !last_ff) |=> !$rose(rsp_valid_ff))
      else $error("response raised on a non-final corner");

   // Emitting a sum clears the running sum.
   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> sum_ff == '0)
      else $error("running sum not cleared on emit");
`endif

endmodule
